### hw/rtl/i2cms_pkg.sv
package i2cms_pkg;

    // command codes, same values as the request kind field
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WMSB  = 3'd3,
        CMD_WLSB  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    localparam int unsigned PHASE_W    = 6;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned S_USER_W   = 3;
    localparam int unsigned M_DATA_W   = 16;

    // write phase decode: phase p below 24 maps to {bit step p/3, sub phase p%3}
    localparam logic [4:0] WR_STEP [32] = '{
        5'd0,  5'd1,  5'd2,
        5'd4,  5'd5,  5'd6,
        5'd8,  5'd9,  5'd10,
        5'd12, 5'd13, 5'd14,
        5'd16, 5'd17, 5'd18,
        5'd20, 5'd21, 5'd22,
        5'd24, 5'd25, 5'd26,
        5'd28, 5'd29, 5'd30,
        5'd0,  5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0
    };

    localparam logic [1:0] SUB_DRIVE  = 2'd0;
    localparam logic [1:0] SUB_RISE   = 2'd1;
    localparam logic [1:0] SUB_SAMPLE = 2'd2;
    localparam logic [1:0] SUB_FALL   = 2'd3;

endpackage

### hw/rtl/i2c_master_bit_sequencer.sv
// Channel   Dir  Ports                    Contents
// s_        in   tvalid tready tdata tuser one tick: pin samples, optional command
// m_        out  tvalid tready tdata       pin drives and status after that tick
//
// One request is taken per clock unless a result is stalled; its result appears in the
// output register on the next cycle, so the sustained rate is one tick per clock.
// While a command runs, its state advances by one pin phase for every request taken.
// aresetn (synchronous) returns the sequencer to idle with both lines released.
// A stalled result blocks new requests only while it has not been taken.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // data_byte[7:0], sda_in[8], scl_in[9], zeros
    input  logic [S_USER_W-1:0]   s_tuser,   // kind[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // sda_drive, scl_drive, busy_res, done_res,
                                             // status_bit, read_data[12:5], zeros
);

    logic                 s_accept;
    logic [2:0]           kind;
    logic [7:0]           data_byte;
    logic                 sda_in;
    logic                 scl_in;

    cmd_t                 command_reg,  command_next;
    logic [PHASE_W-1:0]   phase_reg,    phase_next;
    logic [7:0]           shift_reg,    shift_next;
    logic [7:0]           accum_reg,    accum_next;
    logic                 sda_reg,      sda_next;
    logic                 scl_reg,      scl_next;
    logic                 status_reg,   status_next;
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg,   m_data_next;

    logic                 new_cmd;
    logic                 done;
    cmd_t                 cmd_eff;
    logic [PHASE_W-1:0]   phase_eff;
    logic [7:0]           shift_eff;
    logic [4:0]           wr_step;
    logic [2:0]           wr_pos;

    assign kind      = s_tuser[2:0];
    assign data_byte = s_tdata[7:0];
    assign sda_in    = s_tdata[8];
    assign scl_in    = s_tdata[9];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        new_cmd   = (command_reg == CMD_IDLE) && (kind >= 3'(CMD_START))
                    && (kind <= 3'(CMD_READ));
        cmd_eff   = new_cmd ? cmd_t'(kind) : command_reg;
        phase_eff = new_cmd ? '0 : phase_reg;
        if (new_cmd) begin
            shift_eff = (cmd_t'(kind) == CMD_WMSB || cmd_t'(kind) == CMD_WLSB)
                        ? data_byte : 8'h00;
        end else begin
            shift_eff = shift_reg;
        end

        wr_step = WR_STEP[phase_eff[4:0]];
        wr_pos  = (cmd_eff == CMD_WMSB) ? (3'd7 - wr_step[4:2]) : wr_step[4:2];

        command_next = cmd_eff;
        phase_next   = phase_eff;
        shift_next   = shift_eff;
        accum_next   = accum_reg;
        sda_next     = sda_reg;
        scl_next     = scl_reg;
        status_next  = status_reg;
        done         = 1'b0;

        if (cmd_eff != CMD_IDLE) begin
            unique case (cmd_eff)
                CMD_START: begin
                    case (phase_eff)
                        6'd0: sda_next = 1'b1;
                        6'd1: scl_next = 1'b1;
                        6'd2: begin
                            if (sda_in && scl_in) begin
                                sda_next = 1'b0;
                            end else begin
                                // bus busy: abort without touching the lines
                                status_next = 1'b1;
                                done        = 1'b1;
                            end
                        end
                        6'd3: begin
                            scl_next    = 1'b0;
                            status_next = 1'b0;
                            done        = 1'b1;
                        end
                        default: done = 1'b1;
                    endcase
                end
                CMD_STOP: begin
                    case (phase_eff)
                        6'd0: scl_next = 1'b0;
                        6'd1: sda_next = 1'b0;
                        6'd2: scl_next = 1'b1;
                        6'd3: begin
                            sda_next = 1'b1;
                            done     = 1'b1;
                        end
                        default: done = 1'b1;
                    endcase
                end
                CMD_WMSB, CMD_WLSB: begin
                    if (phase_eff < 6'd24) begin
                        case (wr_step[1:0])
                            SUB_DRIVE: sda_next = shift_eff[wr_pos];
                            SUB_RISE:  scl_next = 1'b1;
                            default:   scl_next = 1'b0;
                        endcase
                    end else begin
                        case (phase_eff)
                            6'd24: sda_next    = 1'b1;
                            6'd25: scl_next    = 1'b1;
                            6'd26: status_next = sda_in;
                            6'd27: begin
                                scl_next = 1'b0;
                                done     = 1'b1;
                            end
                            default: done = 1'b1;
                        endcase
                    end
                end
                CMD_READ: begin
                    if (!phase_eff[5]) begin
                        case (phase_eff[1:0])
                            SUB_DRIVE:  sda_next = 1'b1;
                            SUB_RISE:   scl_next = 1'b1;
                            SUB_SAMPLE: shift_next[phase_eff[4:2]] = sda_in;
                            SUB_FALL: begin
                                scl_next = 1'b0;
                                if (phase_eff[4:0] == 5'd31) begin
                                    accum_next = shift_eff;
                                    done       = 1'b1;
                                end
                            end
                            default: scl_next = 1'b0;
                        endcase
                    end else begin
                        done = 1'b1;
                    end
                end
                default: done = 1'b1;
            endcase

            if (done) begin
                command_next = CMD_IDLE;
                phase_next   = '0;
            end else begin
                phase_next = phase_eff + 6'd1;
            end
        end

        m_data_next = {3'b000, accum_next, status_next, done,
                       (command_next != CMD_IDLE), scl_next, sda_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_reg <= CMD_IDLE;
            phase_reg   <= '0;
            shift_reg   <= '0;
            accum_reg   <= '0;
            sda_reg     <= 1'b1;
            scl_reg     <= 1'b1;
            status_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                command_reg <= command_next;
                phase_reg   <= phase_next;
                shift_reg   <= shift_next;
                accum_reg   <= accum_next;
                sda_reg     <= sda_next;
                scl_reg     <= scl_next;
                status_reg  <= status_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // a finished command never reports busy on the same tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[2] && m_data_reg[3]))
        else $error("busy and done both set");

    // idle sequencer keeps its phase counter cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (command_reg == CMD_IDLE) |-> (phase_reg == '0))
        else $error("phase count nonzero while idle");

    // no request taken while a result is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_accept)
        else $error("request accepted over a stalled result");

    // busy flag in the result tracks the command register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_data_reg[2] == (command_reg != CMD_IDLE)))
        else $error("busy flag disagrees with command state");

endmodule
